// ===== rtl/core/lrusr_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU stack page replacement package
// Sizes, the controller-to-datapath command word and page width conversions.
// ----------------------------------------------------------------------------
package lrusr_pkg;

    localparam int FRAMES    = 8;
    localparam int PAGE_BITS = 16;

    // Fixed widths of the stream fields.
    localparam int IN_PAGE_W = 16;
    localparam int EVP_W     = 16;
    localparam int OCC_W     = 4;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 24;

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [CNT_W-1:0]     count_t;
    typedef logic [IDX_W-1:0]     index_t;

    typedef struct packed {
        logic load_page;
        logic update;
    } lrusr_cmd_t;

    // Only the low PAGE_BITS bits of a referenced page are used.
    function automatic page_t page_from_input(input logic [IN_PAGE_W-1:0] value);
        page_t p;
        p = '0;
        for (int i = 0; i < PAGE_BITS; i++)
        begin
            if (i < IN_PAGE_W)
            begin
                p[i] = value[i];
            end
        end
        return p;
    endfunction

    function automatic logic [EVP_W-1:0] page_to_output(input page_t value);
        logic [EVP_W-1:0] r;
        r = '0;
        for (int i = 0; i < EVP_W; i++)
        begin
            if (i < PAGE_BITS)
            begin
                r[i] = value[i];
            end
        end
        return r;
    endfunction

    function automatic logic [OCC_W-1:0] count_to_occupancy(input count_t value);
        logic [OCC_W-1:0] r;
        r = '0;
        for (int i = 0; i < OCC_W; i++)
        begin
            if (i < CNT_W)
            begin
                r[i] = value[i];
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/lrusr_ctrl.sv =====
// ----------------------------------------------------------------------------
// LRU stack controller
// Sequences one reference at a time: capture the page, then update the stack
// and load the result register once that register is free.
// ----------------------------------------------------------------------------
module lrusr_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output lrusr_pkg::lrusr_cmd_t cmd
);
    import lrusr_pkg::*;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   result_free;

    // The result register can take a new word when empty or being drained.
    assign result_free = !out_valid_reg || out_ready;

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign cmd.load_page = (state_reg == ST_IDLE) && in_valid;
    assign cmd.update    = (state_reg == ST_UPDATE) && result_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (in_valid)
                    begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    if (result_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg     <= ST_IDLE;
                    out_valid_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/lrusr_datapath.sv =====
// ----------------------------------------------------------------------------
// LRU stack datapath
// Holds the stack of resident pages, compares all slots against the captured
// page and performs the hit, push or evict update in one step.
// ----------------------------------------------------------------------------
module lrusr_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  lrusr_pkg::lrusr_cmd_t           cmd,
    input  logic [lrusr_pkg::IN_PAGE_W-1:0] page_number,
    output logic                            hit,
    output logic                            evict_valid,
    output logic [lrusr_pkg::EVP_W-1:0]     evicted_page,
    output logic [lrusr_pkg::OCC_W-1:0]     occupancy
);
    import lrusr_pkg::*;

    page_t              entries_reg [FRAMES];
    logic [FRAMES-1:0]  valid_reg;
    count_t             count_reg;
    page_t              page_reg;

    logic               hit_reg;
    logic               evict_reg;
    logic [EVP_W-1:0]   evp_reg;
    logic [OCC_W-1:0]   occ_reg;

    logic [FRAMES-1:0]  match;
    logic               found;
    index_t             found_idx;
    logic               full;
    count_t             top;

    page_t              entries_next [FRAMES];
    logic [FRAMES-1:0]  valid_next;
    count_t             count_next;

    assign full = (count_reg == count_t'(FRAMES));
    assign top  = count_reg - count_t'(1);

    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            match[i] = valid_reg[i] && (count_t'(i) < count_reg)
                       && (entries_reg[i] == page_reg);
        end
    end

    // The lowest matching slot wins; pages are never stored twice.
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                found     = 1'b1;
                found_idx = index_t'(i);
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < FRAMES; i++)
        begin
            entries_next[i] = entries_reg[i];
            valid_next[i]   = valid_reg[i];
        end
        if (found)
        begin
            // Slots from the hit up to below the top shift down; page goes on top.
            for (int i = 0; i < FRAMES - 1; i++)
            begin
                if ((index_t'(i) >= found_idx) && (count_t'(i + 1) < count_reg))
                begin
                    entries_next[i] = entries_reg[i + 1];
                    valid_next[i]   = valid_reg[i + 1];
                end
            end
            for (int i = 0; i < FRAMES; i++)
            begin
                if (count_t'(i) == top)
                begin
                    entries_next[i] = page_reg;
                    valid_next[i]   = 1'b1;
                end
            end
        end
        else if (!full)
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                if (count_t'(i) == count_reg)
                begin
                    entries_next[i] = page_reg;
                    valid_next[i]   = 1'b1;
                end
            end
            count_next = count_reg + count_t'(1);
        end
        else
        begin
            for (int i = 0; i < FRAMES - 1; i++)
            begin
                entries_next[i] = entries_reg[i + 1];
                valid_next[i]   = valid_reg[i + 1];
            end
            entries_next[FRAMES-1] = page_reg;
            valid_next[FRAMES-1]   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.update)
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_page)
        begin
            page_reg <= page_from_input(page_number);
        end
        if (cmd.update)
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                entries_reg[i] <= entries_next[i];
            end
            hit_reg   <= found;
            evict_reg <= !found && full;
            evp_reg   <= (!found && full) ? page_to_output(entries_reg[0]) : '0;
            occ_reg   <= count_to_occupancy(count_next);
        end
    end

    assign hit          = hit_reg;
    assign evict_valid  = evict_reg;
    assign evicted_page = evp_reg;
    assign occupancy    = occ_reg;

endmodule

// ===== rtl/core/lru_stack_page_replacement.sv =====
// ----------------------------------------------------------------------------
// LRU stack page replacement
// Tracks resident pages in least-recently-used order and reports evictions.
// ----------------------------------------------------------------------------
// Each input word names a referenced page; each reference yields exactly one
// output word with the hit flag, the eviction flag, the evicted page (zero
// when nothing was evicted) and the number of resident pages afterwards.
// A reference is handled in steps: first the page is captured, then all stack
// slots are compared at once and the stack is shifted and written. The
// next page is taken while the previous result still waits in the output
// register; the update step stalls only when that register is still full.
// After reset the stack is empty and usable at once.
// ----------------------------------------------------------------------------
module lru_stack_page_replacement
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [15:0] page_number
    input  logic [lrusr_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [0] hit, [1] evict_valid, [17:2] evicted_page, [21:18] occupancy,
    // [23:22] zero
    output logic [lrusr_pkg::OUT_W-1:0] m_axis_tdata
);
    import lrusr_pkg::*;

    lrusr_cmd_t        cmd;
    logic              hit;
    logic              evict_valid;
    logic [EVP_W-1:0]  evicted_page;
    logic [OCC_W-1:0]  occupancy;

    lrusr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    lrusr_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .page_number  (s_axis_tdata[IN_PAGE_W-1:0]),
        .hit          (hit),
        .evict_valid  (evict_valid),
        .evicted_page (evicted_page),
        .occupancy    (occupancy)
    );

    assign m_axis_tdata = {2'b00, occupancy, evicted_page, evict_valid, hit};

endmodule
